[hw/rtl/foafir_pkg.sv]
package foafir_pkg;

	// internal complex word: 24-bit signed parts, real part in the low half
	localparam int W = 24;
	localparam int TAP_DEPTH = 65;
	localparam int TW_FRAC = 22;
	localparam int TAP_FRAC = 15;
	localparam int OUT_FRAC = 7;
	localparam int IN_SHIFT = 7;

	typedef logic signed [W-1:0] word_t;

	typedef struct packed {
		word_t im;
		word_t re;
	} cword_t;

	// operation riding along the arithmetic pipeline
	typedef struct packed {
		logic mul;   // bin product instead of butterfly
		logic halve; // halve butterfly outputs (forward sample transform)
	} op_t;

	function automatic word_t sat24(input logic signed [39:0] v);
		word_t r;
		if (v > 40'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -40'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/foafir_dp.sv]
// Shared arithmetic: complex product, rounding, butterfly add/sub, saturation.
// Operands enter at s1, results leave at s4.
module foafir_dp (
	input  logic                clk,
	input  foafir_pkg::op_t     op_s1,
	input  foafir_pkg::cword_t  a_s1,
	input  foafir_pkg::cword_t  b_s1,
	input  foafir_pkg::cword_t  w_s1,
	output foafir_pkg::cword_t  r0_s4,
	output foafir_pkg::cword_t  r1_s4
);

	foafir_pkg::op_t    op_s2, op_s3;
	foafir_pkg::cword_t a_s2, a_s3;
	logic signed [47:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [34:0] tr_s3, ti_s3;

	logic signed [48:0] sr, si, rnd, tr_full, ti_full;
	logic signed [36:0] sum_re, sum_im, dif_re, dif_im;
	logic signed [36:0] hs_re, hs_im, hd_re, hd_im;

	always_comb begin
		sr = 49'(p_rr_s2) - 49'(p_ii_s2);
		si = 49'(p_ri_s2) + 49'(p_ir_s2);
		rnd = op_s2.mul ? 49'sd16384 : 49'sd2097152;
		if (op_s2.mul) begin
			tr_full = (sr + rnd) >>> foafir_pkg::TAP_FRAC;
			ti_full = (si + rnd) >>> foafir_pkg::TAP_FRAC;
		end else begin
			tr_full = (sr + rnd) >>> foafir_pkg::TW_FRAC;
			ti_full = (si + rnd) >>> foafir_pkg::TW_FRAC;
		end
	end

	always_comb begin
		sum_re = 37'(a_s3.re) + 37'(tr_s3);
		sum_im = 37'(a_s3.im) + 37'(ti_s3);
		dif_re = 37'(a_s3.re) - 37'(tr_s3);
		dif_im = 37'(a_s3.im) - 37'(ti_s3);
		hs_re = (sum_re + 37'sd1) >>> 1;
		hs_im = (sum_im + 37'sd1) >>> 1;
		hd_re = (dif_re + 37'sd1) >>> 1;
		hd_im = (dif_im + 37'sd1) >>> 1;
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		a_s2 <= a_s1;
		p_rr_s2 <= w_s1.re * b_s1.re;
		p_ii_s2 <= w_s1.im * b_s1.im;
		p_ri_s2 <= w_s1.re * b_s1.im;
		p_ir_s2 <= w_s1.im * b_s1.re;

		op_s3 <= op_s2;
		a_s3 <= a_s2;
		tr_s3 <= tr_full[34:0];
		ti_s3 <= ti_full[34:0];

		if (op_s3.mul) begin
			r0_s4.re <= foafir_pkg::sat24(40'(tr_s3));
			r0_s4.im <= foafir_pkg::sat24(40'(ti_s3));
			r1_s4 <= '0;
		end else if (op_s3.halve) begin
			r0_s4.re <= foafir_pkg::sat24(40'(hs_re));
			r0_s4.im <= foafir_pkg::sat24(40'(hs_im));
			r1_s4.re <= foafir_pkg::sat24(40'(hd_re));
			r1_s4.im <= foafir_pkg::sat24(40'(hd_im));
		end else begin
			r0_s4.re <= foafir_pkg::sat24(40'(sum_re));
			r0_s4.im <= foafir_pkg::sat24(40'(sum_im));
			r1_s4.re <= foafir_pkg::sat24(40'(dif_re));
			r1_s4.im <= foafir_pkg::sat24(40'(dif_im));
		end
	end

endmodule

[hw/rtl/fft_overlap_add_fir_core.sv]
// FIR filter by FFT fast convolution with overlap-add.
// Input channel s_*: tuser = 0 carries an audio sample, tuser = 1 a tap write.
// Output channel m_*: one filtered sample for each audio sample item, none for
// tap writes. Output equals the linear convolution of the input with the taps
// delayed by FFT_POINTS samples, saturated to 16 bits.
// An ordinary sample goes from ST_IDLE to ST_OUT, which loads the output
// register and raises m_tvalid. Every FFT_POINTS/2-th sample then runs the
// frame: load, forward FFT, bin products, inverse FFT, overlap add. Each FFT
// uses one butterfly unit; the two results of a butterfly are written one
// after the other through the single write port of the frame memory.
// A tap write holds the block while the coefficient spectrum is rebuilt:
// the taps are loaded into the frame memory and a forward FFT runs.
// After reset a clearing pass zeroes the tap store, spectrum, playback and
// overlap memories; s_tready stays low meanwhile.
// A finished sample waits in the output register; the next item is taken in
// the same cycle it leaves. A stalled receiver holds the block after that.
module fft_overlap_add_fir_core #(
	parameter int FFT_POINTS = 128,
	parameter int TAP_COUNT = 55
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // sample_in[15:0], tap_index[22:16], tap_value[38:23]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // sample_out[15:0]
);

	localparam int LOG = $clog2(FFT_POINTS);
	localparam int HALF = FFT_POINTS / 2;
	localparam int QUART = FFT_POINTS / 4;
	localparam int AW = LOG + 1;
	localparam int HW = LOG - 1;
	localparam int TD = foafir_pkg::TAP_DEPTH;
	localparam int USED0 = (TAP_COUNT < TD) ? TAP_COUNT : TD;
	localparam int USED = (USED0 < FFT_POINTS) ? USED0 : FFT_POINTS;
	localparam int CLR_N = (FFT_POINTS > TD) ? FFT_POINTS : TD;
	localparam int CW = $clog2(CLR_N + 1);
	localparam int SW = $clog2(LOG);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_OUT   = 8'b0000_0100,
		ST_TLOAD = 8'b0000_1000,
		ST_LOAD  = 8'b0001_0000,
		ST_FFT   = 8'b0010_0000,
		ST_MUL   = 8'b0100_0000,
		ST_ADD   = 8'b1000_0000
	} state_t;

	typedef foafir_pkg::word_t tw_tab_t [HALF];

	// Q1.22 cosine from an eleven-term Taylor series in Q30
	function automatic foafir_pkg::word_t cosq(input int m);
		longint unsigned x, x2, term;
		longint sum;
		x = 64'd6746518852 * 64'(m) / FFT_POINTS;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd306; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd380; sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		return foafir_pkg::word_t'((sum + 128) >>> 8);
	endfunction

	function automatic tw_tab_t mk_tw_re();
		tw_tab_t t;
		for (int k = 0; k < HALF; k++) begin
			t[k] = (k <= QUART) ? cosq(k) : -cosq(HALF - k);
		end
		return t;
	endfunction

	function automatic tw_tab_t mk_tw_im();
		tw_tab_t t;
		for (int k = 0; k < HALF; k++) begin
			t[k] = (k <= QUART) ? -cosq(QUART - k) : -cosq(k - QUART);
		end
		return t;
	endfunction

	localparam tw_tab_t TW_RE = mk_tw_re();
	localparam tw_tab_t TW_IM = mk_tw_im();

	function automatic logic [LOG-1:0] bitrev(input logic [LOG-1:0] v);
		logic [LOG-1:0] r;
		for (int i = 0; i < LOG; i++) begin
			r[i] = v[LOG-1-i];
		end
		return r;
	endfunction

	// memories: frame (work half low, spectrum half high), taps, gather,
	// playback (two banks), overlap tail
	foafir_pkg::cword_t fmem [2*FFT_POINTS];
	logic signed [15:0] tapm [TD];
	logic signed [15:0] gmem [HALF];
	foafir_pkg::word_t  pmem [FFT_POINTS];
	foafir_pkg::word_t  tmem [HALF];

	foafir_pkg::cword_t rd_a_q, rd_b_q;
	logic signed [15:0] tap_rd_q, g_rd_q;
	foafir_pkg::word_t  p_rd_q, t_rd_q;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   stage_q;
	logic            phase_q, dr_q, tgt_q, inv_q, halve_q, bank_q;
	logic [HW-1:0]   pos_q;
	logic            out_v_q;
	logic [15:0]     out_q;

	logic            l_v_s1, l_in_s1, l_tgt_s1, l_gain_s1;
	logic [LOG-1:0]  l_idx_s1;
	logic            a_v_s1;
	logic [HW-1:0]   a_idx_s1;

	logic            v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]   a0_s1, a0_s2, a0_s3, a0_s4;
	logic [AW-1:0]   a1_s1, a1_s2, a1_s3, a1_s4;
	foafir_pkg::op_t    op_s1;
	foafir_pkg::cword_t w_s1, dp_w, r0_s4, r1_s4;
	logic            pend_q;
	logic [AW-1:0]   pend_a_q;
	foafir_pkg::cword_t pend_d_q;

	logic            s_acc, busy, iss_fft, iss_mul;
	logic [HW-1:0]   kk, lowmask, lo, hi, tw_idx;
	logic [LOG-1:0]  bf_i, bf_b, hbit;
	logic [AW-1:0]   f_ra, f_rb, f_wa;
	logic            f_we;
	foafir_pkg::cword_t f_wd, w_iss, l_data;
	logic signed [24:0] y_rnd, y_sh;
	logic signed [15:0] y_sat;
	logic [6:0]      tap_ra;

	assign s_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && (!out_v_q || m_tready);
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || pend_q;

	// butterfly addressing for the current stage
	always_comb begin
		kk = cnt_q[HW-1:0];
		lowmask = (HW'(1) << stage_q) - HW'(1);
		lo = kk & lowmask;
		hi = kk & ~lowmask;
		bf_i = {hi, 1'b0} | {1'b0, lo};
		hbit = LOG'(1) << stage_q;
		bf_b = bf_i | hbit;
		tw_idx = HW'(lo << (SW'(LOG - 1) - stage_q));
		w_iss.re = TW_RE[tw_idx];
		w_iss.im = inv_q ? -TW_IM[tw_idx] : TW_IM[tw_idx];
		iss_fft = (state_q == ST_FFT) && !dr_q && !phase_q;
		iss_mul = (state_q == ST_MUL) && !dr_q;
	end

	// the bin products stay in natural order, so the inverse transform and the
	// overlap add find butterfly index i at address bitrev(i)
	always_comb begin
		case (state_q)
			ST_FFT: begin
				if (inv_q) begin
					f_ra = {tgt_q, bitrev(bf_i)};
					f_rb = {tgt_q, bitrev(bf_b)};
				end else begin
					f_ra = {tgt_q, bf_i};
					f_rb = {tgt_q, bf_b};
				end
			end
			ST_MUL: begin
				f_ra = {1'b1, cnt_q[LOG-1:0]};
				f_rb = {1'b0, cnt_q[LOG-1:0]};
			end
			ST_ADD: begin
				f_ra = {1'b0, bitrev({1'b0, cnt_q[HW-1:0]})};
				f_rb = {1'b0, bitrev({1'b1, cnt_q[HW-1:0]})};
			end
			default: begin
				f_ra = '0;
				f_rb = '0;
			end
		endcase
	end

	always_comb begin
		l_data.im = '0;
		if (!l_in_s1) begin
			l_data.re = '0;
		end else if (l_gain_s1) begin
			l_data.re = foafir_pkg::word_t'(g_rd_q) <<< foafir_pkg::IN_SHIFT;
		end else begin
			l_data.re = foafir_pkg::word_t'(tap_rd_q);
		end
	end

	// single write port of the frame memory
	always_comb begin
		f_we = 1'b0;
		f_wa = '0;
		f_wd = '0;
		if (state_q == ST_CLEAR) begin
			f_we = cnt_q < CW'(FFT_POINTS);
			f_wa = {1'b1, cnt_q[LOG-1:0]};
		end else if (l_v_s1) begin
			f_we = 1'b1;
			f_wa = {l_tgt_s1, bitrev(l_idx_s1)};
			f_wd = l_data;
		end else if (v_s4) begin
			f_we = 1'b1;
			f_wa = a0_s4;
			f_wd = r0_s4;
		end else if (pend_q) begin
			f_we = 1'b1;
			f_wa = pend_a_q;
			f_wd = pend_d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_wa] <= f_wd;
		end
		rd_a_q <= fmem[f_ra];
		rd_b_q <= fmem[f_rb];
	end

	assign tap_ra = (cnt_q < CW'(TD)) ? cnt_q[6:0] : 7'd0;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (cnt_q < CW'(TD)) begin
				tapm[cnt_q[6:0]] <= '0;
			end
		end else if (s_acc && s_tuser && (s_tdata[22:16] < 7'(TD))) begin
			tapm[s_tdata[22:16]] <= s_tdata[38:23];
		end
		tap_rd_q <= tapm[tap_ra];
	end

	always_ff @(posedge clk) begin
		if (s_acc && !s_tuser) begin
			gmem[pos_q] <= s_tdata[15:0];
		end
		g_rd_q <= gmem[cnt_q[HW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (cnt_q < CW'(FFT_POINTS)) begin
				pmem[cnt_q[LOG-1:0]] <= '0;
			end
		end else if (a_v_s1) begin
			pmem[{bank_q, a_idx_s1}] <= foafir_pkg::sat24(40'(rd_a_q.re) + 40'(t_rd_q));
		end
		p_rd_q <= pmem[{bank_q, pos_q}];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			if (cnt_q < CW'(HALF)) begin
				tmem[cnt_q[HW-1:0]] <= '0;
			end
		end else if (a_v_s1) begin
			tmem[a_idx_s1] <= rd_b_q.re;
		end
		t_rd_q <= tmem[cnt_q[HW-1:0]];
	end

	assign dp_w = op_s1.mul ? rd_a_q : w_s1;

	foafir_dp u_dp (
		.clk   (clk),
		.op_s1 (op_s1),
		.a_s1  (rd_a_q),
		.b_s1  (rd_b_q),
		.w_s1  (dp_w),
		.r0_s4 (r0_s4),
		.r1_s4 (r1_s4)
	);

	// payload side of the arithmetic pipeline
	always_ff @(posedge clk) begin
		a0_s1 <= iss_mul ? {1'b0, cnt_q[LOG-1:0]} : f_ra;
		a1_s1 <= f_rb;
		op_s1 <= '{mul: iss_mul, halve: halve_q};
		w_s1 <= w_iss;
		a0_s2 <= a0_s1;
		a1_s2 <= a1_s1;
		a0_s3 <= a0_s2;
		a1_s3 <= a1_s2;
		a0_s4 <= a0_s3;
		a1_s4 <= a1_s3;
		pend_a_q <= a1_s4;
		pend_d_q <= r1_s4;
		l_idx_s1 <= cnt_q[LOG-1:0];
		l_in_s1 <= (state_q == ST_LOAD) ? (cnt_q < CW'(HALF)) : (cnt_q < CW'(USED));
		l_tgt_s1 <= state_q == ST_TLOAD;
		l_gain_s1 <= state_q == ST_LOAD;
		a_idx_s1 <= cnt_q[HW-1:0];
	end

	// output rounding: drop 7 fraction bits, half up, saturate to 16 bits
	always_comb begin
		y_rnd = 25'(p_rd_q) + 25'sd64;
		y_sh = y_rnd >>> foafir_pkg::OUT_FRAC;
		if (y_sh > 25'sd32767) begin
			y_sat = 16'sh7fff;
		end else if (y_sh < -25'sd32768) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_sh[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			stage_q <= '0;
			phase_q <= 1'b0;
			dr_q <= 1'b0;
			tgt_q <= 1'b0;
			inv_q <= 1'b0;
			halve_q <= 1'b0;
			bank_q <= 1'b0;
			pos_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			l_v_s1 <= 1'b0;
			a_v_s1 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			v_s1 <= iss_fft || iss_mul;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			pend_q <= v_s4 && (state_q == ST_FFT);
			l_v_s1 <= ((state_q == ST_TLOAD) || (state_q == ST_LOAD))
				&& (cnt_q < CW'(FFT_POINTS));
			a_v_s1 <= (state_q == ST_ADD) && (cnt_q < CW'(HALF));

			if (state_q == ST_OUT) begin
				out_v_q <= 1'b1;
				out_q <= y_sat;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CW'(CLR_N - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						cnt_q <= '0;
						state_q <= s_tuser ? ST_TLOAD : ST_OUT;
					end
				end
				ST_OUT: begin
					if (pos_q == HW'(HALF - 1)) begin
						pos_q <= '0;
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						pos_q <= pos_q + HW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_TLOAD, ST_LOAD: begin
					if (cnt_q == CW'(FFT_POINTS)) begin
						cnt_q <= '0;
						stage_q <= '0;
						phase_q <= 1'b0;
						dr_q <= 1'b0;
						tgt_q <= state_q == ST_TLOAD;
						inv_q <= 1'b0;
						halve_q <= state_q == ST_LOAD;
						state_q <= ST_FFT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_FFT: begin
					if (!dr_q) begin
						phase_q <= !phase_q;
						if (phase_q) begin
							if (cnt_q == CW'(HALF - 1)) begin
								cnt_q <= '0;
								dr_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + CW'(1);
							end
						end
					end else if (!busy) begin
						dr_q <= 1'b0;
						if (stage_q == SW'(LOG - 1)) begin
							stage_q <= '0;
							cnt_q <= '0;
							if (tgt_q) begin
								state_q <= ST_IDLE;
							end else if (!inv_q) begin
								state_q <= ST_MUL;
							end else begin
								state_q <= ST_ADD;
							end
						end else begin
							stage_q <= stage_q + SW'(1);
						end
					end
				end
				ST_MUL: begin
					if (!dr_q) begin
						if (cnt_q == CW'(FFT_POINTS - 1)) begin
							cnt_q <= '0;
							dr_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end else if (!busy) begin
						dr_q <= 1'b0;
						stage_q <= '0;
						phase_q <= 1'b0;
						tgt_q <= 1'b0;
						inv_q <= 1'b1;
						halve_q <= 1'b0;
						state_q <= ST_FFT;
					end
				end
				ST_ADD: begin
					if (cnt_q == CW'(HALF)) begin
						cnt_q <= '0;
						bank_q <= !bank_q;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_wr_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s4 && pend_q))
		else $error("butterfly write collision on frame memory");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == ST_OUT))
		else $error("output item raised outside sample state");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> $past(state_q == ST_ADD))
		else $error("playback bank flipped outside overlap add");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(busy || l_v_s1 || a_v_s1 || dr_q))
		else $error("idle with frame work in flight");

endmodule
